/* rtl/kdll_pkg.sv */
// Shared types, constants and operation codes for the keyed doubly linked list.
// Used by the list cell and the top level; no dependencies of its own.
package kdll_pkg;

    // Capacity and derived widths
    localparam int NODES   = 16;
    localparam int IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W   = $clog2(NODES + 1);
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 4;
    localparam int STAT_W  = 3;
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = ((2 * DATA_W + CNT_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND   = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PREPEND  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AFT  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_INS_BEF  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_UPDATE   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_UPD_ALL  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_REMOVE   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_SEARCH   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_WALK_FWD = 4'd9;
    localparam logic [FUNC_W-1:0] FN_WALK_REV = 4'd10;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_ANCHOR = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_KEY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        CO_HOLD = 3'd0,
        CO_INS  = 3'd1,
        CO_REM  = 3'd2,
        CO_UPD  = 3'd3,
        CO_ALL  = 3'd4,
        CO_CLR  = 3'd5
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] anchor;
    } t_cell_cmd;

    typedef struct packed {
        logic key_hit;
        logic anc_hit;
    } t_cell_hit;

endpackage

/* rtl/keyed_doubly_linked_list.sv */
// Keyed ordered list built from a row of kdll_cell positions, head at cell 0.
// Depends on kdll_pkg and kdll_cell.
//
// Usage:
//   Input channel (s_axis): one operation per transfer; the operation code
//   travels in tuser, the entry key, value and anchor key in tdata.
//   Output channel (m_axis): status in tuser, key, value and entry count in
//   tdata, tlast high on the final result of an operation.
//   The list is kept in order across the cells: entry n of the list sits in
//   cell n. Inserts shift the tail one cell right, removes one cell left, all
//   cells compare their keys in parallel, so every operation other than a
//   walk gives a single registered result in the cycle after the transfer;
//   a new operation can follow in the next cycle unless the receiver stalls.
//   A walk of N entries reads one cell per cycle through a position counter
//   while the receiver takes results; each result passes the walk state and
//   then the output register, and the input stays blocked until all N
//   entries (up to 16) have been read.
//   Reset empties the list: every cell is marked free.
//   When the receiver stalls, the output register holds its result and the
//   input is taken only once that register can be reloaded.
module keyed_doubly_linked_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: entry_key[31:0], entry_value[63:32], anchor_key[95:64]
    input  logic [kdll_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: func[3:0]
    input  logic [kdll_pkg::FUNC_W-1:0]       i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: out_key[31:0], out_value[63:32], entry_count, zero fill
    output logic [kdll_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [kdll_pkg::STAT_W-1:0]       o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    localparam int NODES  = kdll_pkg::NODES;
    localparam int IDX_W  = kdll_pkg::IDX_W;
    localparam int CNT_W  = kdll_pkg::CNT_W;
    localparam int DATA_W = kdll_pkg::DATA_W;
    localparam int PAD_W  = kdll_pkg::M_TDATA_W - 2 * DATA_W - CNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state r_state, n_state;

    kdll_pkg::t_cell_cmd w_cmd;
    kdll_pkg::t_entry    w_cells [NODES];
    kdll_pkg::t_cell_hit w_hits  [NODES];
    kdll_pkg::t_entry    w_empty;
    kdll_pkg::t_entry    w_new;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_ptr, n_ptr;
    logic [CNT_W-1:0]          r_left, n_left;
    logic                      r_rev, n_rev;

    logic                      r_out_valid;
    logic [kdll_pkg::STAT_W-1:0] r_out_status, n_out_status;
    logic [DATA_W-1:0]         r_out_key, n_out_key;
    logic [DATA_W-1:0]         r_out_value, n_out_value;
    logic [CNT_W-1:0]          r_out_count;
    logic                      r_out_last;

    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_start_walk;
    logic                      w_key_found, w_anc_found;
    logic [IDX_W-1:0]          w_key_pos, w_anc_pos;
    kdll_pkg::t_entry          w_key_entry;
    logic [NODES-1:0]          w_valid_vec;
    logic [kdll_pkg::FUNC_W-1:0] w_func;
    logic [DATA_W-1:0]         w_in_key, w_in_value, w_in_anchor;

    assign w_func      = i_s_axis_tuser;
    assign w_in_key    = i_s_axis_tdata[DATA_W-1:0];
    assign w_in_value  = i_s_axis_tdata[2*DATA_W-1:DATA_W];
    assign w_in_anchor = i_s_axis_tdata[3*DATA_W-1:2*DATA_W];

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_empty = '0;
    assign w_new   = '{valid: 1'b1, key: w_in_key, value: w_in_value};

    // Row of cells, each wired to its left and right neighbor
    for (genvar g = 0; g < NODES; g++) begin : g_cell
        kdll_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  ((g == 0) ? w_new : w_cells[(g == 0) ? 0 : g - 1]),
            .i_right ((g == NODES - 1) ? w_empty
                                       : w_cells[(g == NODES - 1) ? g : g + 1]),
            .o_entry (w_cells[g]),
            .o_hit   (w_hits[g])
        );
        assign w_valid_vec[g] = w_cells[g].valid;
    end

    // Collapse the one-hot hit vectors into found flags, positions and entry
    always_comb begin
        w_key_found = 1'b0;
        w_anc_found = 1'b0;
        w_key_pos   = '0;
        w_anc_pos   = '0;
        w_key_entry = '0;
        for (int i = 0; i < NODES; i++) begin
            if (w_hits[i].key_hit) begin
                w_key_found = 1'b1;
                w_key_pos   = w_key_pos | IDX_W'(i);
                w_key_entry = w_key_entry | w_cells[i];
            end
            if (w_hits[i].anc_hit) begin
                w_anc_found = 1'b1;
                w_anc_pos   = w_anc_pos | IDX_W'(i);
            end
        end
    end

    // Decode the operation into a cell command and a result
    always_comb begin
        w_cmd.op     = kdll_pkg::CO_HOLD;
        w_cmd.pos    = '0;
        w_cmd.key    = w_in_key;
        w_cmd.value  = w_in_value;
        w_cmd.anchor = w_in_anchor;
        n_count      = r_count;
        n_out_status = kdll_pkg::ST_OK;
        n_out_key    = '0;
        n_out_value  = '0;
        w_start_walk = 1'b0;
        case (w_func)
            kdll_pkg::FN_APPEND, kdll_pkg::FN_PREPEND,
            kdll_pkg::FN_INS_AFT, kdll_pkg::FN_INS_BEF: begin
                if ((w_func == kdll_pkg::FN_INS_AFT || w_func == kdll_pkg::FN_INS_BEF)
                    && !w_anc_found) begin
                    n_out_status = kdll_pkg::ST_NO_ANCHOR;
                end else if (w_key_found) begin
                    n_out_status = kdll_pkg::ST_EXISTS;
                end else if (r_count == CNT_W'(NODES)) begin
                    n_out_status = kdll_pkg::ST_FULL;
                end else begin
                    w_cmd.op = kdll_pkg::CO_INS;
                    n_count  = r_count + 1'b1;
                    case (w_func)
                        kdll_pkg::FN_APPEND:  w_cmd.pos = r_count;
                        kdll_pkg::FN_PREPEND: w_cmd.pos = '0;
                        kdll_pkg::FN_INS_AFT: w_cmd.pos = CNT_W'(w_anc_pos) + 1'b1;
                        default:              w_cmd.pos = CNT_W'(w_anc_pos);
                    endcase
                end
            end
            kdll_pkg::FN_UPDATE: begin
                if (w_key_found) begin
                    w_cmd.op  = kdll_pkg::CO_UPD;
                    w_cmd.pos = CNT_W'(w_key_pos);
                end else begin
                    n_out_status = kdll_pkg::ST_NO_KEY;
                end
            end
            kdll_pkg::FN_UPD_ALL: begin
                if (r_count == '0) begin
                    n_out_status = kdll_pkg::ST_EMPTY;
                end else begin
                    w_cmd.op = kdll_pkg::CO_ALL;
                end
            end
            kdll_pkg::FN_REMOVE: begin
                if (w_key_found) begin
                    w_cmd.op  = kdll_pkg::CO_REM;
                    w_cmd.pos = CNT_W'(w_key_pos);
                    n_count   = r_count - 1'b1;
                end else begin
                    n_out_status = kdll_pkg::ST_NO_KEY;
                end
            end
            kdll_pkg::FN_CLEAR: begin
                if (r_count == '0) begin
                    n_out_status = kdll_pkg::ST_EMPTY;
                end else begin
                    w_cmd.op = kdll_pkg::CO_CLR;
                    n_count  = '0;
                end
            end
            kdll_pkg::FN_SEARCH: begin
                if (w_key_found) begin
                    n_out_key   = w_key_entry.key;
                    n_out_value = w_key_entry.value;
                end else begin
                    n_out_status = kdll_pkg::ST_NO_KEY;
                end
            end
            kdll_pkg::FN_WALK_FWD, kdll_pkg::FN_WALK_REV: begin
                if (r_count == '0) begin
                    n_out_status = kdll_pkg::ST_EMPTY;
                end else begin
                    w_start_walk = 1'b1;
                end
            end
            default: begin
                n_out_status = kdll_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_cmd.op     = kdll_pkg::CO_HOLD;
            n_count      = r_count;
            w_start_walk = 1'b0;
        end
    end

    // Walk sequencer: start on a walk transfer, advance one cell per free slot
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_rev   = r_rev;
        case (r_state)
            S_IDLE: begin
                if (w_start_walk) begin
                    n_state = S_WALK;
                    n_rev   = (w_func == kdll_pkg::FN_WALK_REV);
                    n_left  = r_count;
                    n_ptr   = (w_func == kdll_pkg::FN_WALK_REV)
                              ? IDX_W'(r_count - 1'b1) : '0;
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    n_left = r_left - 1'b1;
                    n_ptr  = r_rev ? r_ptr - 1'b1 : r_ptr + 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if ((w_accept && !w_start_walk) || (r_state == S_WALK && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk position and output payload
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_rev <= n_rev;
        if (w_accept && !w_start_walk) begin
            r_out_status <= n_out_status;
            r_out_key    <= n_out_key;
            r_out_value  <= n_out_value;
            r_out_count  <= n_count;
            r_out_last   <= 1'b1;
        end else if (r_state == S_WALK && w_out_free) begin
            r_out_status <= kdll_pkg::ST_OK;
            r_out_key    <= w_cells[r_ptr].key;
            r_out_value  <= w_cells[r_ptr].value;
            r_out_count  <= r_count;
            r_out_last   <= (r_left == CNT_W'(1));
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out_count, r_out_value, r_out_key};

`ifndef SYNTH
    // Entry count tracks the occupied cells
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid_vec)))
        else $error("entry count differs from occupied cells");

    // Occupied cells form one run starting at the head cell
    a_packed_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec & (w_valid_vec + 1'b1)) == '0))
        else $error("occupied cells are not packed from the head");

    // A walk in progress always has entries left to emit
    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_left != '0 && r_left <= r_count))
        else $error("walk counter out of range");

    // A non-walk operation gives a single final result in the next cycle
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_start_walk) |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("missing single result");
`endif

endmodule

/* rtl/kdll_cell.sv */
// One list position: holds an entry and shifts it to or from its neighbors.
// Depends on kdll_pkg for the entry, command and hit types.
module kdll_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [kdll_pkg::IDX_W-1:0]  i_index,
    input  kdll_pkg::t_cell_cmd         i_cmd,
    input  kdll_pkg::t_entry            i_left,
    input  kdll_pkg::t_entry            i_right,
    output kdll_pkg::t_entry            o_entry,
    output kdll_pkg::t_cell_hit         o_hit
);

    kdll_pkg::t_entry r_entry;
    kdll_pkg::t_entry n_entry;
    logic [kdll_pkg::CNT_W-1:0] w_idx;

    assign w_idx = kdll_pkg::CNT_W'(i_index);

    // Compare the stored key against both probe keys
    assign o_hit.key_hit = r_entry.valid && (r_entry.key == i_cmd.key);
    assign o_hit.anc_hit = r_entry.valid && (r_entry.key == i_cmd.anchor);
    assign o_entry       = r_entry;

    // Take the new entry, shift from a neighbor, update the value, clear, or hold
    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            kdll_pkg::CO_INS: begin
                if (w_idx == i_cmd.pos) begin
                    n_entry.valid = 1'b1;
                    n_entry.key   = i_cmd.key;
                    n_entry.value = i_cmd.value;
                end else if (w_idx > i_cmd.pos) begin
                    n_entry = i_left;
                end
            end
            kdll_pkg::CO_REM: begin
                if (w_idx >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            kdll_pkg::CO_UPD: begin
                if (w_idx == i_cmd.pos) begin
                    n_entry.value = i_cmd.value;
                end
            end
            kdll_pkg::CO_ALL: begin
                if (r_entry.valid) begin
                    n_entry.value = i_cmd.value;
                end
            end
            kdll_pkg::CO_CLR: begin
                n_entry.valid = 1'b0;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Clear the valid flag at reset; key and value need none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the keyed doubly linked list.
// Drives one operation per input transfer and predicts every result with an ordered
// queue model; depends only on kdll_pkg and the keyed_doubly_linked_list top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES     = kdll_pkg::NODES;
    localparam int FUNC_W    = kdll_pkg::FUNC_W;
    localparam int STAT_W    = kdll_pkg::STAT_W;
    localparam int CNT_W     = kdll_pkg::CNT_W;
    localparam int DATA_W    = kdll_pkg::DATA_W;
    localparam int S_TDATA_W = kdll_pkg::S_TDATA_W;
    localparam int M_TDATA_W = kdll_pkg::M_TDATA_W;

    // Unused operation codes run from one past the reverse walk up to all ones
    localparam logic [FUNC_W-1:0] FN_LAST_CODE = {FUNC_W{1'b1}};
    localparam logic [DATA_W-1:0] KEY_MIN      = 32'h8000_0000;
    localparam logic [DATA_W-1:0] KEY_MAX      = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam int                POOL_SIZE    = 24;
    localparam int                ITEMS_PHASE  = 56;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_list_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [S_TDATA_W-1:0]    i_s_axis_tdata;
    logic [FUNC_W-1:0]       i_s_axis_tuser;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [M_TDATA_W-1:0]    o_m_axis_tdata;
    logic [STAT_W-1:0]       o_m_axis_tuser;
    logic                    o_m_axis_tlast;

    // Predicted list contents, head first
    logic [DATA_W-1:0]       list_keys[$];
    logic [DATA_W-1:0]       list_values[$];
    t_list_result            expected_results[$];
    logic [DATA_W-1:0]       key_pool[POOL_SIZE];
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      fail_count;

    keyed_doubly_linked_list DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if results stop flowing
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Position of a key in the predicted list, -1 if absent
    function automatic int find_entry(input logic [DATA_W-1:0] key);
        foreach (list_keys[i])
            if (list_keys[i] == key) return i;
        return -1;
    endfunction

    function automatic void push_result(input logic [STAT_W-1:0] status,
                                        input logic [DATA_W-1:0] key,
                                        input logic [DATA_W-1:0] value,
                                        input logic              last);
        t_list_result r;
        r.status = status;
        r.key    = key;
        r.value  = value;
        r.count  = CNT_W'(list_keys.size());
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted operation to the predicted list and queue its results
    task automatic predict_op(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] anchor);
        int                kpos;
        int                apos;
        int                n;
        logic [STAT_W-1:0] status;
        status = kdll_pkg::ST_OK;
        kpos   = find_entry(key);
        apos   = find_entry(anchor);
        n      = list_keys.size();
        case (func)
            kdll_pkg::FN_APPEND, kdll_pkg::FN_PREPEND,
            kdll_pkg::FN_INS_AFT, kdll_pkg::FN_INS_BEF: begin
                // Anchor first, then duplicate key, then capacity
                if ((func == kdll_pkg::FN_INS_AFT || func == kdll_pkg::FN_INS_BEF)
                    && apos < 0) begin
                    status = kdll_pkg::ST_NO_ANCHOR;
                end else if (kpos >= 0) begin
                    status = kdll_pkg::ST_EXISTS;
                end else if (n == NODES) begin
                    status = kdll_pkg::ST_FULL;
                end else begin
                    case (func)
                        kdll_pkg::FN_APPEND: begin
                            list_keys.push_back(key);
                            list_values.push_back(value);
                        end
                        kdll_pkg::FN_PREPEND: begin
                            list_keys.push_front(key);
                            list_values.push_front(value);
                        end
                        kdll_pkg::FN_INS_AFT: begin
                            list_keys.insert(apos + 1, key);
                            list_values.insert(apos + 1, value);
                        end
                        default: begin
                            list_keys.insert(apos, key);
                            list_values.insert(apos, value);
                        end
                    endcase
                end
            end
            kdll_pkg::FN_UPDATE: begin
                if (kpos < 0) status = kdll_pkg::ST_NO_KEY;
                else list_values[kpos] = value;
            end
            kdll_pkg::FN_UPD_ALL: begin
                if (n == 0) status = kdll_pkg::ST_EMPTY;
                else foreach (list_values[i]) list_values[i] = value;
            end
            kdll_pkg::FN_REMOVE: begin
                if (kpos < 0) begin
                    status = kdll_pkg::ST_NO_KEY;
                end else begin
                    list_keys.delete(kpos);
                    list_values.delete(kpos);
                end
            end
            kdll_pkg::FN_CLEAR: begin
                if (n == 0) begin
                    status = kdll_pkg::ST_EMPTY;
                end else begin
                    list_keys.delete();
                    list_values.delete();
                end
            end
            kdll_pkg::FN_SEARCH: begin
                if (kpos < 0)
                    push_result(kdll_pkg::ST_NO_KEY, '0, '0, 1'b1);
                else
                    push_result(kdll_pkg::ST_OK, list_keys[kpos], list_values[kpos], 1'b1);
                return;
            end
            kdll_pkg::FN_WALK_FWD, kdll_pkg::FN_WALK_REV: begin
                // Emit every entry in order, tlast on the final one
                if (n == 0) begin
                    push_result(kdll_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else if (func == kdll_pkg::FN_WALK_FWD) begin
                    for (int i = 0; i < n; i++)
                        push_result(kdll_pkg::ST_OK, list_keys[i], list_values[i],
                                    i == n - 1);
                end else begin
                    for (int i = n - 1; i >= 0; i--)
                        push_result(kdll_pkg::ST_OK, list_keys[i], list_values[i], i == 0);
                end
                return;
            end
            default: ;
        endcase
        push_result(status, '0, '0, 1'b1);
    endtask

    // Present one operation, hold it until the transfer, then predict it
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] value,
                           input logic [DATA_W-1:0] anchor);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {anchor, value, key};
        i_s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_op(func, key, value, anchor);
    endtask

    // Stop sending until every predicted result has been seen
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // A live key with chance live_pct, else one from the shared pool or fully random
    function automatic logic [DATA_W-1:0] pick_key(input int live_pct);
        if (list_keys.size() != 0 && $urandom_range(0, 99) < live_pct)
            return list_keys[$urandom_range(0, list_keys.size() - 1)];
        if ($urandom_range(0, 9) == 0) return $urandom();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 15) return key_pool[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    // Compare each result transfer against the oldest prediction; drive tready
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d key %h", o_m_axis_tuser,
                       o_m_axis_tdata[DATA_W-1:0]);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tdata[DATA_W-1:0] !== want.key) begin
                    $error("out_key: expected %h, got %h", want.key,
                           o_m_axis_tdata[DATA_W-1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[2*DATA_W-1:DATA_W] !== want.value) begin
                    $error("out_value: expected %h, got %h", want.value,
                           o_m_axis_tdata[2*DATA_W-1:DATA_W]);
                    fail_count++;
                end
                if (o_m_axis_tdata[2*DATA_W +: CNT_W] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count,
                           o_m_axis_tdata[2*DATA_W +: CNT_W]);
                    fail_count++;
                end
                if (o_m_axis_tdata[M_TDATA_W-1:2*DATA_W+CNT_W] !== '0) begin
                    $error("zero fill: expected 0, got %h",
                           o_m_axis_tdata[M_TDATA_W-1:2*DATA_W+CNT_W]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Operations that meet an empty list
    task automatic test_empty_list();
        send_op(kdll_pkg::FN_WALK_FWD, '0, '0, '0);
        send_op(kdll_pkg::FN_WALK_REV, ALL_ONES, ALL_ONES, ALL_ONES);
        send_op(kdll_pkg::FN_UPD_ALL, '0, KEY_MAX, '0);
        send_op(kdll_pkg::FN_CLEAR, '0, '0, '0);
        send_op(kdll_pkg::FN_REMOVE, KEY_MIN, '0, '0);
    endtask

    // Each insert form, its check order, update and search
    task automatic test_insert_rules();
        send_op(kdll_pkg::FN_APPEND, KEY_MIN, KEY_MAX, '0);
        send_op(kdll_pkg::FN_PREPEND, KEY_MAX, KEY_MIN, ALL_ONES);
        send_op(kdll_pkg::FN_INS_AFT, '0, ALL_ONES, KEY_MIN);
        send_op(kdll_pkg::FN_INS_BEF, ALL_ONES, '0, KEY_MAX);
        send_op(kdll_pkg::FN_APPEND, '0, 32'h1234_5678, '0);
        // Missing anchor wins over a duplicate key
        send_op(kdll_pkg::FN_INS_BEF, KEY_MIN, '0, 32'h0BAD_0BAD);
        send_op(kdll_pkg::FN_INS_AFT, KEY_MAX, '0, '0);
        send_op(kdll_pkg::FN_UPDATE, '0, 32'hCAFE_F00D, '0);
        send_op(kdll_pkg::FN_SEARCH, '0, '0, '0);
        send_op(kdll_pkg::FN_SEARCH, 32'h0BAD_0BAD, '0, '0);
    endtask

    // Fill to capacity, then hit the full case, walk all entries in reverse and clear
    task automatic test_full_list();
        int i;
        i = 0;
        while (list_keys.size() < NODES) begin
            send_op((i % 2 == 0) ? kdll_pkg::FN_APPEND : kdll_pkg::FN_PREPEND,
                    32'h0100_0000 * (i + 1) + i, pick_value(), '0);
            i++;
        end
        send_op(kdll_pkg::FN_APPEND, 32'h0FAC_E000, '0, '0);
        send_op(kdll_pkg::FN_INS_BEF, 32'h0FAC_E001, '0, KEY_MIN);
        send_op(kdll_pkg::FN_WALK_REV, '0, '0, '0);
        send_op(kdll_pkg::FN_CLEAR, '0, '0, '0);
    endtask

    // Removing the only entry leaves an empty list that accepts new entries
    task automatic test_sole_entry();
        send_op(kdll_pkg::FN_APPEND, 32'h5555_AAAA, 32'hAAAA_5555, '0);
        send_op(kdll_pkg::FN_REMOVE, 32'h5555_AAAA, '0, '0);
        send_op(kdll_pkg::FN_WALK_FWD, '0, '0, '0);
        send_op(kdll_pkg::FN_PREPEND, 32'h0000_0001, 32'h0000_0002, '0);
    endtask

    task automatic test_unused_codes();
        send_op(kdll_pkg::FN_WALK_REV + 1'b1, $urandom(), $urandom(), $urandom());
        send_op(FN_LAST_CODE, $urandom(), $urandom(), $urandom());
    endtask

    // Weighted random operations under one idling and stalling setting
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int num_items);
        int                r;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] key;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < num_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) func = kdll_pkg::FN_APPEND;
            else if (r < 19) func = kdll_pkg::FN_PREPEND;
            else if (r < 28) func = kdll_pkg::FN_INS_AFT;
            else if (r < 37) func = kdll_pkg::FN_INS_BEF;
            else if (r < 46) func = kdll_pkg::FN_UPDATE;
            else if (r < 50) func = kdll_pkg::FN_UPD_ALL;
            else if (r < 67) func = kdll_pkg::FN_REMOVE;
            else if (r < 69) func = kdll_pkg::FN_CLEAR;
            else if (r < 79) func = kdll_pkg::FN_SEARCH;
            else if (r < 87) func = kdll_pkg::FN_WALK_FWD;
            else if (r < 95) func = kdll_pkg::FN_WALK_REV;
            else func = FUNC_W'($urandom_range(kdll_pkg::FN_WALK_REV + 1, FN_LAST_CODE));
            key = (func <= kdll_pkg::FN_INS_BEF) ? pick_key(20) : pick_key(75);
            send_op(func, key, pick_value(), pick_key(80));
        end
        wait_idle();
    endtask

    initial begin
        fail_count      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = ALL_ONES;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_insert_rules();
        test_full_list();
        test_sole_entry();
        test_unused_codes();
        wait_idle();

        test_random_traffic(0, 0, ITEMS_PHASE);
        test_random_traffic(68, 0, ITEMS_PHASE);
        test_random_traffic(0, 68, ITEMS_PHASE);
        test_random_traffic(11, 11, ITEMS_PHASE);

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
